@@ hw/rtl/ihdp_pkg.sv @@
// Shared types, constants and helper functions for the image header dimension probe.
package ihdp_pkg;

   localparam int unsigned BYTE_COUNT_WIDTH = 24;
   localparam int unsigned DIM_WIDTH        = 32;
   localparam int unsigned SEG_LEN_WIDTH    = 16;

   localparam logic [BYTE_COUNT_WIDTH-1:0] BYTE_COUNT_RESET = '0;
   localparam logic                        IMAGE_FORMAT_RESET = 1'b1;

   localparam logic IMAGE_FORMAT_PNG  = 1'b0;
   localparam logic IMAGE_FORMAT_JPEG = 1'b1;

   localparam logic REG_IMAGE_FORMAT = 1'b0;
   localparam logic REG_BYTE_COUNT   = 1'b1;

   localparam logic [7:0] JPEG_FILL     = 8'hFF;
   localparam logic [7:0] JPEG_SOI      = 8'hD8;
   localparam logic [7:0] JPEG_EOI      = 8'hD9;
   localparam logic [7:0] JPEG_TEM      = 8'h01;
   localparam logic [7:0] JPEG_SOS      = 8'hDA;
   localparam logic [7:0] JPEG_SOF_BASE = 8'hC0;

   localparam logic [SEG_LEN_WIDTH-1:0] SOF_MIN_LEN = 16'd7;
   localparam logic [BYTE_COUNT_WIDTH-1:0] PNG_MIN_BYTES = 24'd24;
   localparam logic [BYTE_COUNT_WIDTH-1:0] JPEG_MIN_BYTES = 24'd4;

   typedef enum logic [9:0] {
      PH_IDLE   = 10'b0000000001,
      PH_PNG    = 10'b0000000010,
      PH_JSTART = 10'b0000000100,
      PH_JSOI   = 10'b0000001000,
      PH_JSEEK  = 10'b0000010000,
      PH_JFILL  = 10'b0000100000,
      PH_JLENHI = 10'b0001000000,
      PH_JLENLO = 10'b0010000000,
      PH_JSOF   = 10'b0100000000,
      PH_JSKIP  = 10'b1000000000
   } phase_type;

   typedef struct packed {
      logic                        image_format;
      logic [BYTE_COUNT_WIDTH-1:0] byte_count;
   } cfg_type;

   typedef struct packed {
      logic                 found;
      logic [DIM_WIDTH-1:0] width;
      logic [DIM_WIDTH-1:0] height;
   } verdict_type;

   function automatic logic [7:0] png_sig_byte(input logic [2:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0: b = 8'h89;
         3'd1: b = 8'h50;
         3'd2: b = 8'h4E;
         3'd3: b = 8'h47;
         3'd4: b = 8'h0D;
         3'd5: b = 8'h0A;
         3'd6: b = 8'h1A;
         3'd7: b = 8'h0A;
      endcase
      return b;
   endfunction

   function automatic logic is_standalone(input logic [7:0] m);
      return (m == JPEG_SOI) || (m == JPEG_EOI) || (m == JPEG_TEM) ||
             (m[7:3] == 5'b11010);
   endfunction

   function automatic logic is_sof(input logic [7:0] m);
      return (m[7:4] == JPEG_SOF_BASE[7:4]) && (m[3:0] != 4'h4) &&
             (m[3:0] != 4'h8) && (m[3:0] != 4'hC);
   endfunction

endpackage

@@ hw/rtl/ihdp_csr.sv @@
// Configuration registers: image format select and image byte count.
module ihdp_csr
   import ihdp_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic                        csr_index,
   input  logic [BYTE_COUNT_WIDTH-1:0] csr_write_data,
   output cfg_type                     cfg
);

   logic                        format_ff, format_in;
   logic [BYTE_COUNT_WIDTH-1:0] count_ff, count_in;

   always_comb begin
      format_in = format_ff;
      count_in  = count_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_IMAGE_FORMAT: format_in = csr_write_data[0];
            REG_BYTE_COUNT:   count_in  = csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= IMAGE_FORMAT_RESET;
         count_ff  <= BYTE_COUNT_RESET;
      end else begin
         format_ff <= format_in;
         count_ff  <= count_in;
      end
   end

   assign cfg.image_format = format_ff;
   assign cfg.byte_count   = count_ff;

endmodule

@@ hw/rtl/ihdp_parser.sv @@
// Header parser: per-byte phase machine for PNG header and JPEG marker scanning.
module ihdp_parser
   import ihdp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step_en,
   input  logic [7:0]  data_byte,
   input  logic        first_byte,
   input  cfg_type     cfg,
   output logic        verdict_valid,
   output verdict_type verdict
);

   localparam int unsigned CW = BYTE_COUNT_WIDTH + 2;

   phase_type                   phase_ff, phase_in;
   logic [BYTE_COUNT_WIDTH-1:0] pos_ff, pos_in;
   logic [7:0]                  marker_ff, marker_in;
   logic [SEG_LEN_WIDTH-1:0]    len_ff, len_in;
   logic [SEG_LEN_WIDTH-1:0]    left_ff, left_in;
   logic [DIM_WIDTH-1:0]        wacc_ff, wacc_in;
   logic [DIM_WIDTH-1:0]        hacc_ff, hacc_in;
   logic                        give;
   logic                        ok;

   always_comb begin
      phase_type                   cur_phase;
      logic [BYTE_COUNT_WIDTH-1:0] cur_pos;
      logic [SEG_LEN_WIDTH-1:0]    new_len;
      logic [SEG_LEN_WIDTH-1:0]    k;
      logic [CW-1:0]               total;
      logic [CW-1:0]               p_ext;
      logic [CW-1:0]               next;
      logic                        active;

      cur_phase = phase_ff;
      cur_pos   = pos_ff;
      marker_in = marker_ff;
      len_in    = len_ff;
      left_in   = left_ff;
      wacc_in   = wacc_ff;
      hacc_in   = hacc_ff;
      give      = 1'b0;
      ok        = 1'b0;
      new_len   = '0;
      k         = '0;
      total     = {2'b00, cfg.byte_count};

      if (first_byte) begin
         cur_phase = (cfg.image_format == IMAGE_FORMAT_JPEG) ? PH_JSTART : PH_PNG;
         cur_pos   = '0;
         marker_in = '0;
         len_in    = '0;
         left_in   = '0;
         wacc_in   = '0;
         hacc_in   = '0;
      end
      active   = first_byte || (cur_phase != PH_IDLE);
      phase_in = cur_phase;
      pos_in   = cur_pos;
      p_ext    = {2'b00, cur_pos};
      next     = p_ext + CW'(1);

      if (active) begin
         if (p_ext >= total) begin
            give = 1'b1;
         end else begin
            pos_in = next[BYTE_COUNT_WIDTH-1:0];
            unique case (cur_phase)
               PH_PNG: begin
                  if (cfg.byte_count < PNG_MIN_BYTES) begin
                     give = 1'b1;
                  end else if (cur_pos < 24'd8) begin
                     give = (data_byte != png_sig_byte(cur_pos[2:0]));
                  end else if (cur_pos >= 24'd16 && cur_pos < 24'd20) begin
                     wacc_in = {wacc_ff[DIM_WIDTH-9:0], data_byte};
                  end else if (cur_pos >= 24'd20 && cur_pos < 24'd24) begin
                     hacc_in = {hacc_ff[DIM_WIDTH-9:0], data_byte};
                     if (cur_pos == 24'd23) begin
                        give = 1'b1;
                        ok   = (wacc_in != '0) && (hacc_in != '0);
                     end
                  end
               end
               PH_JSTART: begin
                  if (cfg.byte_count < JPEG_MIN_BYTES || data_byte != JPEG_FILL) begin
                     give = 1'b1;
                  end else begin
                     phase_in = PH_JSOI;
                  end
               end
               PH_JSOI: begin
                  if (data_byte != JPEG_SOI || !((next + CW'(3)) < total)) begin
                     give = 1'b1;
                  end else begin
                     phase_in = PH_JSEEK;
                  end
               end
               PH_JSEEK: begin
                  if (data_byte == JPEG_FILL) begin
                     phase_in = PH_JFILL;
                  end
                  if (next >= total) begin
                     give = 1'b1;
                  end
               end
               PH_JFILL: begin
                  if (data_byte == JPEG_FILL) begin
                     give = (next >= total);
                  end else begin
                     marker_in = data_byte;
                     if (is_standalone(data_byte)) begin
                        if (!((next + CW'(3)) < total)) begin
                           give = 1'b1;
                        end else begin
                           phase_in = PH_JSEEK;
                        end
                     end else if ((next + CW'(2)) > total) begin
                        give = 1'b1;
                     end else begin
                        phase_in = PH_JLENHI;
                     end
                  end
               end
               PH_JLENHI: begin
                  len_in   = {data_byte, 8'h00};
                  phase_in = PH_JLENLO;
               end
               PH_JLENLO: begin
                  new_len = {len_ff[SEG_LEN_WIDTH-1:8], data_byte};
                  len_in  = new_len;
                  if (new_len < SEG_LEN_WIDTH'(2) ||
                      (p_ext - CW'(1) + CW'(new_len)) > total) begin
                     give = 1'b1;
                  end else begin
                     left_in = new_len - SEG_LEN_WIDTH'(2);
                     if (is_sof(marker_ff) && new_len >= SOF_MIN_LEN) begin
                        phase_in = PH_JSOF;
                     end else if (marker_ff == JPEG_SOS) begin
                        give = 1'b1;
                     end else if (!((next + CW'(left_in) + CW'(3)) < total)) begin
                        give = 1'b1;
                     end else begin
                        phase_in = (left_in != '0) ? PH_JSKIP : PH_JSEEK;
                     end
                  end
               end
               PH_JSOF: begin
                  k       = (len_ff - SEG_LEN_WIDTH'(2)) - left_ff;
                  left_in = left_ff - SEG_LEN_WIDTH'(1);
                  if (k == SEG_LEN_WIDTH'(1) || k == SEG_LEN_WIDTH'(2)) begin
                     hacc_in = {16'h0000, hacc_ff[7:0], data_byte};
                  end else if (k == SEG_LEN_WIDTH'(3) || k == SEG_LEN_WIDTH'(4)) begin
                     wacc_in = {16'h0000, wacc_ff[7:0], data_byte};
                  end
                  if (k >= SEG_LEN_WIDTH'(4)) begin
                     if (wacc_in != '0 && hacc_in != '0) begin
                        give = 1'b1;
                        ok   = 1'b1;
                     end else begin
                        wacc_in = '0;
                        hacc_in = '0;
                        if (!((next + CW'(left_in) + CW'(3)) < total)) begin
                           give = 1'b1;
                        end else begin
                           phase_in = (left_in != '0) ? PH_JSKIP : PH_JSEEK;
                        end
                     end
                  end
               end
               PH_JSKIP: begin
                  if (left_ff != '0) begin
                     left_in = left_ff - SEG_LEN_WIDTH'(1);
                  end
                  if (left_in == '0) begin
                     phase_in = PH_JSEEK;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
      if (give) begin
         phase_in = PH_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         pos_ff    <= '0;
         marker_ff <= '0;
         len_ff    <= '0;
         left_ff   <= '0;
         wacc_ff   <= '0;
         hacc_ff   <= '0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         marker_ff <= marker_in;
         len_ff    <= len_in;
         left_ff   <= left_in;
         wacc_ff   <= wacc_in;
         hacc_ff   <= hacc_in;
      end
   end

   assign verdict_valid  = step_en && give;
   assign verdict.found  = ok;
   assign verdict.width  = ok ? wacc_in : '0;
   assign verdict.height = ok ? hacc_in : '0;

   a_idle_after_verdict: assert property (@(posedge clock) disable iff (reset)
      verdict_valid |=> phase_ff == PH_IDLE)
      else $error("Parser did not return to idle after a verdict.");

   a_found_nonzero: assert property (@(posedge clock) disable iff (reset)
      verdict_valid && verdict.found |-> verdict.width != '0 && verdict.height != '0)
      else $error("Positive verdict carries a zero dimension.");

   a_position_advance: assert property (@(posedge clock) disable iff (reset)
      step_en && !first_byte && phase_ff != PH_IDLE && !give
      |=> pos_ff == $past(pos_ff) + BYTE_COUNT_WIDTH'(1))
      else $error("Byte position did not advance by one on a parsed byte.");

endmodule

@@ hw/rtl/ihdp_out_stage.sv @@
// Result register that holds one verdict until the result transfer completes.
module ihdp_out_stage
   import ihdp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  verdict_type          verdict,
   input  logic                 rsp_ready,
   output logic                 slot_free,
   output logic                 rsp_valid,
   output logic                 rsp_found,
   output logic [DIM_WIDTH-1:0] rsp_width,
   output logic [DIM_WIDTH-1:0] rsp_height
);

   logic        valid_ff, valid_in;
   verdict_type data_ff;

   assign slot_free = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= verdict;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_found  = data_ff.found;
   assign rsp_width  = data_ff.width;
   assign rsp_height = data_ff.height;

endmodule

@@ hw/rtl/image_header_dimension_probe.sv @@
// Top level of the image header dimension probe: input register, parser and result register.
//
// The probe takes one image byte per cycle while not stalled and gives at most one verdict per
// image, found with width and height or a rejection, on the byte at which the answer is settled.
// A byte is registered on its transfer, parsed by the phase machine once the result register
// can take a verdict, and its verdict, if any, is presented from the result register in the
// cycle after the parse step. With the result side ready, one byte is taken every cycle; the
// parse step advances only while the result register is empty or being emptied, so a stalled
// verdict holds the input side after one buffered byte.
// Configuration is to be written between images; the block itself does not enforce this.
module image_header_dimension_probe
   import ihdp_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_data_byte,
   input  logic                        req_first_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_found,
   output logic [DIM_WIDTH-1:0]        rsp_width,
   output logic [DIM_WIDTH-1:0]        rsp_height,
   input  logic                        csr_write_enable,
   input  logic                        csr_index,
   input  logic [BYTE_COUNT_WIDTH-1:0] csr_write_data
);

   cfg_type     cfg;
   verdict_type verdict;
   logic        verdict_valid;
   logic        slot_free;
   logic        step;
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_data_ff;
   logic        in_first_ff;

   assign step        = in_valid_ff && slot_free;
   assign req_ready   = !in_valid_ff || step;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff  <= req_data_byte;
         in_first_ff <= req_first_byte;
      end
   end

   ihdp_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   ihdp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step_en       (step),
      .data_byte     (in_data_ff),
      .first_byte    (in_first_ff),
      .cfg           (cfg),
      .verdict_valid (verdict_valid),
      .verdict       (verdict)
   );

   ihdp_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (verdict_valid),
      .verdict    (verdict),
      .rsp_ready  (rsp_ready),
      .slot_free  (slot_free),
      .rsp_valid  (rsp_valid),
      .rsp_found  (rsp_found),
      .rsp_width  (rsp_width),
      .rsp_height (rsp_height)
   );

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the image header dimension probe with directed and random streams.
`timescale 1ns / 100ps

module tb;
   import ihdp_pkg::*;

   localparam logic [63:0] PNG_MAGIC = 64'h89504E470D0A1A0A;
   localparam logic [7:0]  MARK_RST_FIRST = 8'hD0;
   localparam logic [7:0]  MARK_RST_LAST  = 8'hD7;
   localparam logic [7:0]  MARK_SOF_LAST  = 8'hCF;
   localparam logic [7:0]  MARK_DHT       = 8'hC4;
   localparam logic [7:0]  MARK_JPG       = 8'hC8;
   localparam logic [7:0]  MARK_DAC       = 8'hCC;

   typedef struct packed {
      logic [7:0] data;
      logic       first;
   } byte_item_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [7:0]                  req_data_byte = '0;
   logic                        req_first_byte = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic                        rsp_found;
   logic [DIM_WIDTH-1:0]        rsp_width;
   logic [DIM_WIDTH-1:0]        rsp_height;
   logic                        csr_write_enable = 1'b0;
   logic                        csr_index = 1'b0;
   logic [BYTE_COUNT_WIDTH-1:0] csr_write_data = '0;

   byte_item_type pending_bytes[$];
   verdict_type   verdict_queue[$];
   logic [7:0]    image_bytes[$];

   logic        byte_taken = 1'b0;
   int unsigned fault_count = 0;
   int unsigned parsed_count = 0;
   bit          calm = 1'b0;
   int unsigned idle_odds = 6;
   int unsigned stall_odds = 6;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;

   logic        probe_format;
   int unsigned probe_count;
   phase_type   probe_phase;
   int unsigned probe_pos;
   logic [7:0]  probe_marker;
   int unsigned probe_len;
   int unsigned probe_left;
   int unsigned probe_w;
   int unsigned probe_h;

   image_header_dimension_probe u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_first_byte   (req_first_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_width        (rsp_width),
      .rsp_height       (rsp_height),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [7:0] rand_byte(input int unsigned lo, input int unsigned hi);
      return 8'($urandom_range(lo, hi));
   endfunction

   function automatic bit lone_marker(input logic [7:0] m);
      return m == JPEG_SOI || m == JPEG_EOI || m == JPEG_TEM ||
             (m >= MARK_RST_FIRST && m <= MARK_RST_LAST);
   endfunction

   function automatic bit frame_marker(input logic [7:0] m);
      return m >= JPEG_SOF_BASE && m <= MARK_SOF_LAST &&
             m != MARK_DHT && m != MARK_JPG && m != MARK_DAC;
   endfunction

   function automatic bit leave_segment(input int unsigned nxt, input int unsigned total);
      if (!(nxt + probe_left + 3 < total)) return 1'b1;
      probe_phase = (probe_left != 0) ? PH_JSKIP : PH_JSEEK;
      return 1'b0;
   endfunction

   function automatic bit predict_verdict(input logic [7:0] d, input logic first,
                                          output verdict_type v);
      int unsigned total, p, nxt, k;
      bit done, ok;
      total = probe_count;
      done = 1'b0;
      ok = 1'b0;
      v = '0;
      if (first) begin
         probe_pos = 0;
         probe_marker = '0;
         probe_len = 0;
         probe_left = 0;
         probe_w = 0;
         probe_h = 0;
         probe_phase = (probe_format == IMAGE_FORMAT_JPEG) ? PH_JSTART : PH_PNG;
      end else if (probe_phase == PH_IDLE) begin
         return 1'b0;
      end
      if (probe_pos >= total) begin
         done = 1'b1;
      end else begin
         p = probe_pos;
         nxt = p + 1;
         probe_pos = nxt;
         case (probe_phase)
            PH_PNG: begin
               if (total < 32'(PNG_MIN_BYTES)) begin
                  done = 1'b1;
               end else if (p < 8) begin
                  done = (d != PNG_MAGIC[63 - 8*p -: 8]);
               end else if (p >= 16 && p < 20) begin
                  probe_w = (probe_w << 8) | 32'(d);
               end else if (p >= 20 && p < 24) begin
                  probe_h = (probe_h << 8) | 32'(d);
                  if (p == 23) begin
                     done = 1'b1;
                     ok = probe_w != 0 && probe_h != 0;
                  end
               end
            end
            PH_JSTART: begin
               if (total < 32'(JPEG_MIN_BYTES) || d != JPEG_FILL) done = 1'b1;
               else probe_phase = PH_JSOI;
            end
            PH_JSOI: begin
               if (d != JPEG_SOI || !(nxt + 3 < total)) done = 1'b1;
               else probe_phase = PH_JSEEK;
            end
            PH_JSEEK: begin
               if (d == JPEG_FILL) probe_phase = PH_JFILL;
               if (nxt >= total) done = 1'b1;
            end
            PH_JFILL: begin
               if (d == JPEG_FILL) begin
                  done = (nxt >= total);
               end else begin
                  probe_marker = d;
                  if (lone_marker(d)) begin
                     if (!(nxt + 3 < total)) done = 1'b1;
                     else probe_phase = PH_JSEEK;
                  end else if (nxt + 2 > total) begin
                     done = 1'b1;
                  end else begin
                     probe_phase = PH_JLENHI;
                  end
               end
            end
            PH_JLENHI: begin
               probe_len = 32'({d, 8'h00});
               probe_phase = PH_JLENLO;
            end
            PH_JLENLO: begin
               probe_len = (probe_len | 32'(d)) & 32'h0000_FFFF;
               if (probe_len < 2 || (p - 1) + probe_len > total) begin
                  done = 1'b1;
               end else begin
                  probe_left = probe_len - 2;
                  if (frame_marker(probe_marker) && probe_len >= 32'(SOF_MIN_LEN))
                     probe_phase = PH_JSOF;
                  else if (probe_marker == JPEG_SOS)
                     done = 1'b1;
                  else
                     done = leave_segment(nxt, total);
               end
            end
            PH_JSOF: begin
               k = (probe_len - 2) - probe_left;
               probe_left = (probe_left - 1) & 32'h0000_FFFF;
               if (k == 1 || k == 2) probe_h = ((probe_h << 8) | 32'(d)) & 32'h0000_FFFF;
               else if (k == 3 || k == 4) probe_w = ((probe_w << 8) | 32'(d)) & 32'h0000_FFFF;
               if (k >= 4) begin
                  if (probe_w != 0 && probe_h != 0) begin
                     done = 1'b1;
                     ok = 1'b1;
                  end else begin
                     probe_w = 0;
                     probe_h = 0;
                     done = leave_segment(nxt, total);
                  end
               end
            end
            PH_JSKIP: begin
               if (probe_left != 0) probe_left--;
               if (probe_left == 0) probe_phase = PH_JSEEK;
            end
            default: probe_phase = PH_IDLE;
         endcase
      end
      if (done) begin
         v.found = ok;
         v.width = ok ? probe_w : '0;
         v.height = ok ? probe_h : '0;
         probe_phase = PH_IDLE;
      end
      return done;
   endfunction

   always @(negedge clock) begin : driver
      byte_item_type b;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (req_valid && !byte_taken) begin
      end else if (gap_left != 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (pending_bytes.size() != 0 && (calm || $urandom_range(0, idle_odds) != 0)) begin
         b = pending_bytes.pop_front();
         req_valid <= 1'b1;
         req_data_byte <= b.data;
         req_first_byte <= b.first;
      end else begin
         req_valid <= 1'b0;
         if (pending_bytes.size() != 0) gap_left = $urandom_range(0, 8);
      end
   end

   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, stall_odds) == 0) begin
         stall_left = $urandom_range(0, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      verdict_type pv, want;
      if (reset) begin
         byte_taken <= 1'b0;
         probe_format = IMAGE_FORMAT_RESET;
         probe_count = 32'(BYTE_COUNT_RESET);
         probe_phase = PH_IDLE;
         probe_pos = 0;
         probe_marker = '0;
         probe_len = 0;
         probe_left = 0;
         probe_w = 0;
         probe_h = 0;
      end else begin
         byte_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            parsed_count++;
            if (predict_verdict(req_data_byte, req_first_byte, pv)) verdict_queue.push_back(pv);
         end
         if (csr_write_enable) begin
            if (csr_index == REG_IMAGE_FORMAT) probe_format = csr_write_data[0];
            else probe_count = 32'(csr_write_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (verdict_queue.size() == 0) begin
               $error("verdict with none pending: found %0d width %0d height %0d",
                      rsp_found, rsp_width, rsp_height);
               fault_count++;
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_found);
                  fault_count++;
               end
               if (rsp_width !== want.width) begin
                  $error("width: expected %0d, actual %0d", want.width, rsp_width);
                  fault_count++;
               end
               if (rsp_height !== want.height) begin
                  $error("height: expected %0d, actual %0d", want.height, rsp_height);
                  fault_count++;
               end
            end
         end
      end
   end

   task automatic write_reg(input logic idx, input logic [BYTE_COUNT_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic push_byte(input logic [7:0] data, input logic first);
      byte_item_type b;
      b.data = data;
      b.first = first;
      pending_bytes.push_back(b);
   endtask

   task automatic push_noise(input int unsigned n, input bit with_first);
      repeat (n) push_byte(rand_byte(0, 255), with_first && $urandom_range(0, 7) == 0);
   endtask

   task automatic settle();
      while (pending_bytes.size() != 0 || req_valid || verdict_queue.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic feed_image();
      int unsigned cut;
      cut = image_bytes.size();
      if (cut > 1 && $urandom_range(0, 7) == 0) cut = $urandom_range(1, cut - 1);
      for (int unsigned i = 0; i < cut; i++) push_byte(image_bytes[i], i == 0);
   endtask

   function automatic logic [31:0] pick_dim(input bit wide);
      logic [31:0] mask;
      int unsigned sel;
      mask = wide ? 32'hFFFF_FFFF : 32'h0000_FFFF;
      sel = $urandom_range(0, 9);
      if (sel == 0) return '0;
      if (sel == 1) return mask;
      if (sel == 2) return $urandom_range(1, 16);
      return $urandom & mask;
   endfunction

   function automatic logic [7:0] pick_sof();
      logic [7:0] m;
      do m = JPEG_SOF_BASE + rand_byte(0, 15); while (!frame_marker(m));
      return m;
   endfunction

   function automatic logic [7:0] pick_plain();
      logic [7:0] m;
      do m = rand_byte(0, 254); while (lone_marker(m) || frame_marker(m) || m == JPEG_SOS);
      return m;
   endfunction

   task automatic build_image(input logic fmt, input int unsigned room);
      logic [31:0] h, w;
      logic [15:0] len;
      int unsigned segs, kind;
      image_bytes.delete();
      if (fmt == IMAGE_FORMAT_PNG) begin
         for (int i = 0; i < 8; i++) image_bytes.push_back(PNG_MAGIC[63 - 8*i -: 8]);
         if ($urandom_range(0, 14) == 0)
            image_bytes[$urandom_range(0, 7)] ^= rand_byte(1, 255);
         if ($urandom_range(0, 3) != 0) begin
            image_bytes.push_back(8'h00);
            image_bytes.push_back(8'h00);
            image_bytes.push_back(8'h00);
            image_bytes.push_back(8'h0D);
            image_bytes.push_back(8'h49);
            image_bytes.push_back(8'h48);
            image_bytes.push_back(8'h44);
            image_bytes.push_back(8'h52);
         end else begin
            repeat (8) image_bytes.push_back(rand_byte(0, 255));
         end
         w = pick_dim(1'b1);
         h = pick_dim(1'b1);
         for (int i = 3; i >= 0; i--) image_bytes.push_back(w[8*i +: 8]);
         for (int i = 3; i >= 0; i--) image_bytes.push_back(h[8*i +: 8]);
         repeat ($urandom_range(0, 6)) image_bytes.push_back(rand_byte(0, 255));
      end else begin
         image_bytes.push_back(($urandom_range(0, 24) == 0) ? rand_byte(0, 255) : JPEG_FILL);
         image_bytes.push_back(($urandom_range(0, 24) == 0) ? rand_byte(0, 255) : JPEG_SOI);
         segs = 0;
         while (image_bytes.size() + 14 < room && segs < 8) begin
            kind = $urandom_range(0, 11);
            segs++;
            case (kind)
               0: repeat ($urandom_range(1, 3)) image_bytes.push_back(rand_byte(0, 254));
               1: begin
                  repeat ($urandom_range(0, 2)) image_bytes.push_back(JPEG_FILL);
                  image_bytes.push_back(JPEG_FILL);
                  case ($urandom_range(0, 3))
                     0: image_bytes.push_back(JPEG_SOI);
                     1: image_bytes.push_back(JPEG_EOI);
                     2: image_bytes.push_back(JPEG_TEM);
                     default: image_bytes.push_back(MARK_RST_FIRST + rand_byte(0, 7));
                  endcase
               end
               2: begin
                  image_bytes.push_back(JPEG_FILL);
                  image_bytes.push_back(pick_sof());
                  image_bytes.push_back(8'h00);
                  image_bytes.push_back(8'h08);
                  image_bytes.push_back(rand_byte(0, 255));
                  h = ($urandom_range(0, 1) == 0) ? '0 : pick_dim(1'b0);
                  w = (h != 0) ? '0 : pick_dim(1'b0);
                  image_bytes.push_back(h[15:8]);
                  image_bytes.push_back(h[7:0]);
                  image_bytes.push_back(w[15:8]);
                  image_bytes.push_back(w[7:0]);
                  image_bytes.push_back(rand_byte(0, 255));
               end
               3: begin
                  len = 16'($urandom_range(2, 6));
                  image_bytes.push_back(JPEG_FILL);
                  image_bytes.push_back(pick_sof());
                  image_bytes.push_back(len[15:8]);
                  image_bytes.push_back(len[7:0]);
                  repeat (len - 2) image_bytes.push_back(rand_byte(0, 255));
               end
               4: begin
                  image_bytes.push_back(JPEG_FILL);
                  image_bytes.push_back(($urandom_range(0, 2) == 0) ? JPEG_SOS : pick_plain());
                  image_bytes.push_back(8'h00);
                  image_bytes.push_back(8'h04);
                  repeat (2) image_bytes.push_back(rand_byte(0, 255));
               end
               5: begin
                  image_bytes.push_back(JPEG_FILL);
                  image_bytes.push_back(pick_plain());
                  image_bytes.push_back(8'h00);
                  image_bytes.push_back(($urandom_range(0, 2) == 0) ? rand_byte(0, 1) : 8'h02);
               end
               default: begin
                  repeat ($urandom_range(0, 2)) image_bytes.push_back(JPEG_FILL);
                  image_bytes.push_back(JPEG_FILL);
                  image_bytes.push_back(pick_plain());
                  len = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(256, 65535))
                                                     : 16'($urandom_range(2, 10));
                  image_bytes.push_back(len[15:8]);
                  image_bytes.push_back(len[7:0]);
                  repeat ((len > 10) ? 4 : len - 2) image_bytes.push_back(rand_byte(0, 255));
               end
            endcase
         end
         if ($urandom_range(0, 11) != 0) begin
            len = 16'($urandom_range(7, 11));
            h = pick_dim(1'b0);
            w = pick_dim(1'b0);
            image_bytes.push_back(JPEG_FILL);
            image_bytes.push_back(pick_sof());
            image_bytes.push_back(len[15:8]);
            image_bytes.push_back(len[7:0]);
            image_bytes.push_back(rand_byte(0, 255));
            image_bytes.push_back(h[15:8]);
            image_bytes.push_back(h[7:0]);
            image_bytes.push_back(w[15:8]);
            image_bytes.push_back(w[7:0]);
            repeat (len - 7) image_bytes.push_back(rand_byte(0, 255));
         end
         repeat ($urandom_range(0, 3)) image_bytes.push_back(rand_byte(0, 255));
      end
   endtask

   task automatic random_phase();
      logic                        fmt;
      logic [BYTE_COUNT_WIDTH-1:0] count;
      int unsigned                 room, n;
      fmt = ($urandom_range(0, 2) == 0) ? IMAGE_FORMAT_PNG : IMAGE_FORMAT_JPEG;
      room = $urandom_range(12, 90);
      build_image(fmt, room);
      n = image_bytes.size();
      case ($urandom_range(0, 19))
         0: count = BYTE_COUNT_WIDTH'($urandom_range(0, 5));
         1: count = '1;
         2: count = BYTE_COUNT_WIDTH'($urandom_range(20, 26));
         3: count = BYTE_COUNT_WIDTH'($urandom_range(65535, 65540));
         default: begin
            if (n > 3 && $urandom_range(0, 4) == 0)
               count = BYTE_COUNT_WIDTH'(n - $urandom_range(1, 3));
            else
               count = BYTE_COUNT_WIDTH'(n + $urandom_range(0, 3));
         end
      endcase
      idle_odds = ($urandom_range(0, 5) == 0) ? 1000 : $urandom_range(2, 12);
      stall_odds = ($urandom_range(0, 5) == 0) ? 1000 : $urandom_range(2, 12);
      write_reg(REG_IMAGE_FORMAT, BYTE_COUNT_WIDTH'(fmt));
      write_reg(REG_BYTE_COUNT, count);
      if ($urandom_range(0, 3) == 0) push_noise($urandom_range(1, 3), 1'b0);
      feed_image();
      repeat ($urandom_range(0, 2)) begin
         if ($urandom_range(0, 5) == 0) push_noise($urandom_range(1, 4), 1'b1);
         build_image(fmt, room);
         feed_image();
      end
      settle();
   endtask

   initial begin : stimulus
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Registers at their reset values: a stray byte is ignored, then an empty image.
      push_byte(8'h00, 1'b0);
      push_byte(JPEG_FILL, 1'b1);
      settle();

      write_reg(REG_IMAGE_FORMAT, BYTE_COUNT_WIDTH'(IMAGE_FORMAT_JPEG));
      write_reg(REG_BYTE_COUNT, JPEG_MIN_BYTES);
      push_byte(JPEG_FILL, 1'b1);
      push_byte(JPEG_SOI, 1'b0);
      push_byte(JPEG_FILL, 1'b0);
      push_byte(JPEG_EOI, 1'b0);
      settle();

      // Largest byte count, a fill byte, and the largest frame size.
      write_reg(REG_BYTE_COUNT, '1);
      push_byte(JPEG_FILL, 1'b1);
      push_byte(JPEG_SOI, 1'b0);
      push_byte(JPEG_FILL, 1'b0);
      push_byte(JPEG_FILL, 1'b0);
      push_byte(JPEG_SOF_BASE, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(SOF_MIN_LEN[7:0], 1'b0);
      repeat (5) push_byte(8'hFF, 1'b0);
      // This image is left unfinished, so it gives no verdict before the next phase.
      push_byte(JPEG_FILL, 1'b1);
      push_byte(JPEG_SOI, 1'b0);
      settle();

      while (parsed_count < 1400) random_phase();
      calm = 1'b1;
      while (parsed_count < 1550) random_phase();
      settle();

      if (fault_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #(20_000_000);
      $display("TB_ERROR");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/ihdp_pkg.sv
hw/rtl/ihdp_csr.sv
hw/rtl/ihdp_parser.sv
hw/rtl/ihdp_out_stage.sv
hw/rtl/image_header_dimension_probe.sv
test/tb.sv
